// ===== rtl/cidat_pkg.sv =====
package cidat_pkg;

  // default table size and master card reset value
  localparam int unsigned TABLE_DEPTH_DEF = 8;
  localparam logic [31:0] MASTER_ID_RST   = 32'hBA3D_F306;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 4;

  // request operations
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MASTER  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MEMBER  = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   card_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

endpackage

// ===== rtl/cidat_if.sv =====
interface cidat_in_if import cidat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ID_W-1:0]     card_id;

  modport source (output valid, output func, output card_id, input ready);
  modport sink   (input valid, input func, input card_id, output ready);
endinterface

interface cidat_out_if import cidat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ===== rtl/cidat_table.sv =====
module cidat_table import cidat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  req_t        req,
  input  logic [ID_W-1:0] master_id,
  output rsp_t        rsp
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [ID_W-1:0]        ids_r [TABLE_DEPTH];
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [TABLE_DEPTH-1:0] match;
  logic                   hit;
  logic [IDX_W-1:0]       slot;
  logic [IDX_W-1:0]       last_idx;
  logic                   full;
  logic                   do_add;
  logic                   do_del;
  logic [STATUS_W-1:0]    status;

  // parallel compare against valid slots
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (CNT_W'(i) < count_r) && (ids_r[i] == req.card_id);
    end
  end

  // members are unique, so the matching index is an or of masked indices
  always_comb begin
    slot = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match[i]) begin
        slot = slot | IDX_W'(i);
      end
    end
  end

  assign hit      = |match;
  assign full     = (count_r == CNT_W'(TABLE_DEPTH));
  assign last_idx = IDX_W'(count_r - CNT_W'(1));

  // operation decode
  always_comb begin
    do_add = 1'b0;
    do_del = 1'b0;
    unique case (req.func)
      FUNC_ADD: begin
        if (req.card_id == master_id) begin
          status = ST_MASTER;
        end else if (hit) begin
          status = ST_MEMBER;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          status = ST_OK;
          do_add = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (hit) begin
          status = ST_OK;
          do_del = 1'b1;
        end else begin
          status = ST_MISSING;
        end
      end
      default: begin
        status = hit ? ST_OK : ST_MISSING;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_add) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign rsp.status      = status;
  assign rsp.entry_count = COUNT_W'(count_nxt);

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

  // slot storage: add fills the next free slot, delete pulls the last one down
  always_ff @(posedge clk) begin
    if (fire && do_add) begin
      ids_r[count_r[IDX_W-1:0]] <= req.card_id;
    end else if (fire && do_del) begin
      ids_r[slot] <= ids_r[last_idx];
    end
  end

`ifndef SYNTHESIS
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("more than one slot holds the same id");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && do_add |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("accepted add did not grow the table");

  a_refused_add_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (req.func == FUNC_ADD) && (status != ST_OK) |=> $stable(count_r))
    else $error("refused add changed the entry count");
`endif

endmodule

// ===== rtl/card_id_access_table_top.sv =====
// channel  | dir | handshake      | payload
// in_req   | in  | valid / ready  | func[1:0], card_id[31:0]
// out_rsp  | out | valid / ready  | status[2:0], entry_count[3:0]
// cfg      | in  | cfg_we         | cfg_wdata[31:0] -> master id
//
// one request per cycle while out_rsp is ready; a result is presented once its
// request has passed the input register, loaded at the accepting edge, and the
// result register (on fire); the table compare and count update sit between them
// reset is synchronous and empties the table at once, no clearing pass
// a stalled result holds in the result register while the next request waits
// in the input register; both sides move every cycle when out_rsp is ready
module card_id_access_table_top import cidat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  cidat_in_if.sink           in_req,
  cidat_out_if.source        out_rsp,
  input  logic               cfg_we,
  input  logic [ID_W-1:0]    cfg_wdata
);

  logic            in_v_r;
  req_t            in_req_r;
  logic            out_v_r;
  rsp_t            out_rsp_r;
  logic [ID_W-1:0] master_r;
  logic            fire;
  rsp_t            tbl_rsp;

  assign fire         = in_v_r && (!out_v_r || out_rsp.ready);
  assign in_req.ready = !in_v_r || fire;

  // master card register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= MASTER_ID_RST;
    end else if (cfg_we) begin
      master_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_req.ready) begin
      in_v_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      in_req_r.func    <= in_req.func;
      in_req_r.card_id <= in_req.card_id;
    end
  end

  cidat_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .req       (in_req_r),
    .master_id (master_r),
    .rsp       (tbl_rsp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rsp_r <= tbl_rsp;
    end
  end

  assign out_rsp.valid       = out_v_r;
  assign out_rsp.status      = out_rsp_r.status;
  assign out_rsp.entry_count = out_rsp_r.entry_count;

endmodule
